FILE: hdl/sne_pkg.sv
// ----------------------------------------------------------------------------
// Sparse network evaluator package
// Shared constants, command/status types, controller states and the
// saturated sigmoid lookup used by the datapath.
// ----------------------------------------------------------------------------
package sne_pkg;

    // Default sizes
    localparam int MAX_NODES_DEF   = 32;
    localparam int MAX_LINKS_DEF   = 8;
    localparam int MAX_OUTPUTS_DEF = 16;

    // Reset values of the configuration registers
    localparam logic [5:0] INPUT_COUNT_RST  = 6'd1;
    localparam logic [4:0] OUTPUT_COUNT_RST = 5'd1;
    localparam logic [5:0] NODE_COUNT_RST   = 6'd2;
    localparam logic [5:0] PASS_LIMIT_RST   = 6'd21;

    // Item function codes
    localparam logic [1:0] FUNC_LINK  = 2'd0;
    localparam logic [1:0] FUNC_COUNT = 2'd1;
    localparam logic [1:0] FUNC_VALUE = 2'd2;
    localparam logic [1:0] FUNC_RUN   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd1;
    localparam logic [1:0] CFG_NODE_COUNT   = 2'd2;
    localparam logic [1:0] CFG_PASS_LIMIT   = 2'd3;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RUN_INIT,
        S_PASS_START,
        S_NODE_START,
        S_LINK_RD,
        S_LINK_CHK,
        S_LINK_ACC,
        S_NODE_SAT,
        S_NODE_SIG,
        S_WB,
        S_PASS_END,
        S_OUT_START,
        S_OUT_LOAD,
        S_OUT_WAIT,
        S_CLEAR
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic run_init;
        logic pass_start;
        logic node_start;
        logic link_rd;
        logic link_chk;
        logic link_acc;
        logic node_sat;
        logic node_sig;
        logic wb_step;
        logic pass_end;
        logic out_start;
        logic out_load;
        logic out_next;
        logic clear;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic no_nodes;
        logic cnt_zero;
        logic link_last;
        logic node_last;
        logic pass_more;
        logic out_none;
        logic out_last;
        logic out_valid;
        logic out_taken;
    } t_sts;

    // round(4096*sigmoid(k/2)), k = 0..16
    function automatic logic [12:0] sig_tab(input logic [4:0] k);
        logic [12:0] v;
        case (k)
            5'd0:    v = 13'd2048;
            5'd1:    v = 13'd2550;
            5'd2:    v = 13'd2994;
            5'd3:    v = 13'd3349;
            5'd4:    v = 13'd3608;
            5'd5:    v = 13'd3785;
            5'd6:    v = 13'd3902;
            5'd7:    v = 13'd3976;
            5'd8:    v = 13'd4022;
            5'd9:    v = 13'd4051;
            5'd10:   v = 13'd4069;
            5'd11:   v = 13'd4079;
            5'd12:   v = 13'd4086;
            5'd13:   v = 13'd4090;
            5'd14:   v = 13'd4092;
            5'd15:   v = 13'd4094;
            default: v = 13'd4095;
        endcase
        return v;
    endfunction

    // Interpolated sigmoid of a Q4.12 value, result unsigned Q1.12
    function automatic logic [12:0] sig_q12(input logic signed [15:0] x);
        logic [16:0] a;
        logic [4:0]  idx;
        logic [10:0] frac;
        logic [12:0] lo;
        logic [12:0] hi;
        logic [9:0]  d;
        logic [20:0] p;
        logic [12:0] v;
        a    = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
        idx  = {1'b0, a[14:11]};
        frac = a[10:0];
        lo   = sig_tab(idx);
        hi   = sig_tab(idx + 5'd1);
        d    = 10'(hi - lo);
        p    = 21'(d) * 21'(frac) + 21'd1024;
        if (a[15]) begin
            v = sig_tab(5'd16);
        end else begin
            v = lo + 13'(p >> 11);
        end
        return x[15] ? (13'd4096 - v) : v;
    endfunction

endpackage

FILE: hdl/sne_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse network evaluator controller
// Sequences load transfers, relaxation passes, node and link steps,
// write-back, result transfers and the end-of-run clear.
// ----------------------------------------------------------------------------
module sne_ctrl
    import sne_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_func == FUNC_RUN) begin
                        n_state = S_RUN_INIT;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_RUN_INIT: begin
                o_cmd.run_init = 1'b1;
                n_state        = S_PASS_START;
            end
            S_PASS_START: begin
                o_cmd.pass_start = 1'b1;
                n_state          = i_sts.no_nodes ? S_PASS_END : S_NODE_START;
            end
            S_NODE_START: begin
                o_cmd.node_start = 1'b1;
                n_state          = i_sts.cnt_zero ? S_NODE_SAT : S_LINK_RD;
            end
            S_LINK_RD: begin
                o_cmd.link_rd = 1'b1;
                n_state       = S_LINK_CHK;
            end
            S_LINK_CHK: begin
                o_cmd.link_chk = 1'b1;
                n_state        = S_LINK_ACC;
            end
            S_LINK_ACC: begin
                o_cmd.link_acc = 1'b1;
                n_state        = i_sts.link_last ? S_NODE_SAT : S_LINK_RD;
            end
            S_NODE_SAT: begin
                o_cmd.node_sat = 1'b1;
                n_state        = S_NODE_SIG;
            end
            S_NODE_SIG: begin
                o_cmd.node_sig = 1'b1;
                n_state        = i_sts.node_last ? S_WB : S_NODE_START;
            end
            S_WB: begin
                o_cmd.wb_step = 1'b1;
                n_state       = i_sts.node_last ? S_PASS_END : S_WB;
            end
            S_PASS_END: begin
                o_cmd.pass_end = 1'b1;
                n_state        = i_sts.pass_more ? S_PASS_START : S_OUT_START;
            end
            S_OUT_START: begin
                o_cmd.out_start = 1'b1;
                n_state         = i_sts.out_none ? S_CLEAR : S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.out_last) begin
                        n_state = S_CLEAR;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state        = S_OUT_LOAD;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A result is only presented while waiting for its transfer
    a_out_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.out_valid |-> (r_state == S_OUT_WAIT))
        else $error("result valid outside result wait");

    // No item is taken while a result is pending
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !i_sts.out_valid)
        else $error("input ready with result pending");

    // Link data is checked in the cycle after the memory read
    a_link_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK_RD) |=> (r_state == S_LINK_CHK))
        else $error("link check did not follow read");
`endif

endmodule

FILE: hdl/sne_dp.sv
// ----------------------------------------------------------------------------
// Sparse network evaluator datapath
// Link memory, link counts, node values, ready flags, per-node sums,
// multiply-accumulate, saturation, sigmoid and the result register.
// ----------------------------------------------------------------------------
module sne_dp
    import sne_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int MAX_LINKS   = MAX_LINKS_DEF,
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    // configuration
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // load fields
    input  logic [1:0]         i_func,
    input  logic [4:0]         i_node_index,
    input  logic [2:0]         i_link_slot,
    input  logic [4:0]         i_source_node,
    input  logic signed [15:0] i_link_weight,
    input  logic [3:0]         i_links_in_use,
    input  logic signed [15:0] i_input_value,
    // results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_output_index,
    output logic [12:0]        o_output_value,
    output logic               o_last
);

    localparam int NW   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int IW   = (NW + 1 > 7) ? NW + 1 : 7;
    localparam int AW   = $clog2(MAX_NODES * MAX_LINKS);
    localparam int KW   = $clog2(MAX_LINKS + 1);
    localparam int OKW  = $clog2(MAX_OUTPUTS + 1);
    localparam int ACCW = 32 + KW;
    localparam int QW   = ACCW - 12;
    localparam logic signed [QW-1:0] QMAX = QW'(32767);
    localparam logic signed [QW-1:0] QMIN = -QW'(32768);

    // Configuration registers
    logic [5:0] r_input_count;
    logic [4:0] r_output_count;
    logic [5:0] r_node_count;
    logic [5:0] r_pass_limit;

    // Storage
    logic [4:0]         r_lsrc [MAX_NODES*MAX_LINKS];
    logic signed [15:0] r_lwgt [MAX_NODES*MAX_LINKS];
    logic [KW-1:0]      r_cnt  [MAX_NODES];
    logic signed [15:0] r_val  [MAX_NODES];
    logic [12:0]        r_sum  [MAX_NODES];
    logic [MAX_NODES-1:0] r_flag;

    // Walk and arithmetic registers
    logic [IW-1:0]      r_node;
    logic [KW-1:0]      r_k;
    logic [5:0]         r_pc;
    logic               r_again;
    logic [4:0]         r_rd_src;
    logic signed [15:0] r_rd_wgt;
    logic               r_ok;
    logic signed [31:0] r_prod;
    logic signed [ACCW-1:0] r_acc;
    logic signed [15:0] r_x;
    logic [OKW-1:0]     r_ok_k;
    logic               r_out_valid;
    logic [3:0]         r_out_index;
    logic [12:0]        r_out_value;
    logic               r_out_last;

    logic [IW-1:0] ncount;
    logic [IW-1:0] icount;
    logic [OKW:0]  ocount;
    logic [6:0]    limit;
    logic [NW-1:0] nidx;
    logic [IW-1:0] src_w;
    logic          src_ok;
    logic [IW-1:0] out_node;
    logic [AW-1:0] ld_addr;
    logic [AW-1:0] rd_addr;
    logic signed [QW-1:0] q;
    logic          out_taken;

    // Effective counts
    always_comb begin
        ncount = (IW'(r_node_count) > IW'(MAX_NODES)) ? IW'(MAX_NODES) : IW'(r_node_count);
        icount = IW'(r_input_count);
        ocount = ((OKW+1)'(r_output_count) > (OKW+1)'(MAX_OUTPUTS))
               ? (OKW+1)'(MAX_OUTPUTS) : (OKW+1)'(r_output_count);
        limit  = (r_pass_limit == 6'd0) ? 7'd1 : 7'(r_pass_limit);
        nidx   = r_node[NW-1:0];
        src_w  = IW'(r_rd_src);
        src_ok = (src_w < IW'(MAX_NODES)) && r_flag[src_w[NW-1:0]];
        out_node = icount + IW'(r_ok_k);
        ld_addr  = AW'(i_node_index) * AW'(MAX_LINKS) + AW'(i_link_slot);
        rd_addr  = AW'(nidx) * AW'(MAX_LINKS) + AW'(r_k);
        q        = r_acc[ACCW-1:12];
        out_taken = r_out_valid && i_out_ready;
    end

    // Status
    always_comb begin
        o_sts.no_nodes  = (icount >= ncount);
        o_sts.cnt_zero  = (r_cnt[nidx] == '0);
        o_sts.link_last = ((r_k + KW'(1)) == r_cnt[nidx]);
        o_sts.node_last = ((r_node + IW'(1)) >= ncount);
        o_sts.pass_more = r_again && ((7'(r_pc) + 7'd1) < limit);
        o_sts.out_none  = (ocount == '0);
        o_sts.out_last  = ((OKW+1)'(r_ok_k) + (OKW+1)'(1)) == ocount;
        o_sts.out_valid = r_out_valid;
        o_sts.out_taken = out_taken;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= INPUT_COUNT_RST;
            r_output_count <= OUTPUT_COUNT_RST;
            r_node_count   <= NODE_COUNT_RST;
            r_pass_limit   <= PASS_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INPUT_COUNT:  r_input_count  <= i_cfg_data[5:0];
                CFG_OUTPUT_COUNT: r_output_count <= i_cfg_data[4:0];
                CFG_NODE_COUNT:   r_node_count   <= i_cfg_data[5:0];
                CFG_PASS_LIMIT:   r_pass_limit   <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Link memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_func == FUNC_LINK &&
            (IW'(i_node_index) < IW'(MAX_NODES)) && (8'(i_link_slot) < 8'(MAX_LINKS))) begin
            r_lsrc[ld_addr] <= i_source_node;
            r_lwgt[ld_addr] <= i_link_weight;
        end
        if (i_cmd.link_rd) begin
            r_rd_src <= r_lsrc[rd_addr];
            r_rd_wgt <= r_lwgt[rd_addr];
        end
    end

    // Link counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_NODES; j++) r_cnt[j] <= '0;
        end else if (i_cmd.load && i_func == FUNC_COUNT &&
                     (IW'(i_node_index) < IW'(MAX_NODES))) begin
            r_cnt[i_node_index[NW-1:0]] <= (8'(i_links_in_use) > 8'(MAX_LINKS))
                                         ? KW'(MAX_LINKS) : KW'(i_links_in_use);
        end
    end

    // Node values: loaded, written back after each pass, cleared after a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int j = 0; j < MAX_NODES; j++) r_val[j] <= '0;
        end else if (i_cmd.load && i_func == FUNC_VALUE &&
                     (IW'(i_node_index) < IW'(MAX_NODES))) begin
            r_val[i_node_index[NW-1:0]] <= i_input_value;
        end else if (i_cmd.wb_step && r_flag[nidx]) begin
            r_val[nidx] <= 16'(r_sum[nidx]);
        end
    end

    // Ready flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_flag <= '0;
        end else if (i_cmd.run_init) begin
            for (int j = 0; j < MAX_NODES; j++) r_flag[j] <= (IW'(j) < icount);
        end else if (i_cmd.node_start) begin
            r_flag[nidx] <= 1'b1;
        end else if (i_cmd.link_chk && !src_ok) begin
            r_flag[nidx] <= 1'b0;
        end
    end

    // Sigmoid results of the current pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_sig) begin
            r_sum[nidx] <= sig_q12(r_x);
        end
    end

    // Node walk, pass counter and pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node  <= '0;
            r_pc    <= '0;
            r_again <= 1'b0;
        end else begin
            if (i_cmd.run_init || i_cmd.clear) begin
                r_pc <= '0;
            end else if (i_cmd.pass_end) begin
                r_pc <= r_pc + 6'd1;
            end
            if (i_cmd.pass_start) begin
                r_node  <= icount;
                r_again <= 1'b0;
            end else if (i_cmd.node_sig) begin
                r_node <= o_sts.node_last ? icount : r_node + IW'(1);
            end else if (i_cmd.wb_step) begin
                r_node <= r_node + IW'(1);
                if (!r_flag[nidx]) r_again <= 1'b1;
            end
        end
    end

    // Multiply-accumulate over the links of one node
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_start) begin
            r_k   <= '0;
            r_acc <= '0;
        end
        if (i_cmd.link_chk) begin
            r_ok   <= src_ok;
            r_prod <= r_val[src_w[NW-1:0]] * r_rd_wgt;
        end
        if (i_cmd.link_acc) begin
            r_k <= r_k + KW'(1);
            if (r_ok) r_acc <= r_acc + ACCW'(r_prod);
        end
        // floor to Q4.12 and saturate
        if (i_cmd.node_sat) begin
            if (q > QMAX) begin
                r_x <= 16'sd32767;
            end else if (q < QMIN) begin
                r_x <= -16'sd32768;
            end else begin
                r_x <= 16'(q);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ok_k      <= '0;
        end else begin
            if (i_cmd.out_start) begin
                r_ok_k <= '0;
            end else if (i_cmd.out_next) begin
                r_ok_k <= r_ok_k + OKW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= 4'(r_ok_k);
            r_out_value <= (out_node < IW'(MAX_NODES)) ? r_val[out_node[NW-1:0]][12:0] : '0;
            r_out_last  <= o_sts.out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_output_index = r_out_index;
    assign o_output_value = r_out_value;
    assign o_last         = r_out_last;

endmodule

FILE: hdl/sparse_network_relaxation_eval.sv
// ----------------------------------------------------------------------------
// Sparse network relaxation evaluator
// Evaluates a sparse weighted network by repeated relaxation passes with a
// saturated sigmoid on each ready node.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries load items (link write,
//   link count, node value) and run items. A run walks passes x nodes x
//   links in a shared multiply-accumulate: each pass evaluates every
//   non-input node and then writes back the ready ones; the number of
//   passes is set by readiness and the pass limit. Each result then goes
//   through the output register (o_out_valid/i_out_ready); o_last marks
//   the final one. A stalled receiver holds the run until each transfer.
//   No input is taken until a run has delivered all results and cleared
//   node values and ready flags.
//   Configuration channel (i_cfg_valid/o_cfg_ready) is always ready; write
//   only while the block is idle.
//   Reset (synchronous, active low) restores register defaults and clears
//   link counts, values and flags; link entries are undefined until written.
// ----------------------------------------------------------------------------
module sparse_network_relaxation_eval
    import sne_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int MAX_LINKS   = MAX_LINKS_DEF,
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [4:0]         i_node_index,
    input  logic [2:0]         i_link_slot,
    input  logic [4:0]         i_source_node,
    input  logic signed [15:0] i_link_weight,
    input  logic [3:0]         i_links_in_use,
    input  logic signed [15:0] i_input_value,
    // results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_output_index,
    output logic [12:0]        o_output_value,
    output logic               o_last
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sne_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_LINKS   (MAX_LINKS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_node_index   (i_node_index),
        .i_link_slot    (i_link_slot),
        .i_source_node  (i_source_node),
        .i_link_weight  (i_link_weight),
        .i_links_in_use (i_links_in_use),
        .i_input_value  (i_input_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_output_index (o_output_index),
        .o_output_value (o_output_value),
        .o_last         (o_last)
    );

endmodule

FILE: sim/tb_sparse_network_relaxation_eval.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sparse network relaxation evaluator
// Loads links, link counts and node values, starts runs under several
// register settings and checks every emitted output node value against an
// in-bench predictor of the relaxation passes or, for some directed runs, a
// fixed expected value, with random idling on both channels, a long receiver
// hold-off and a pause for the results to drain.
module tb_sparse_network_relaxation_eval
    import sne_pkg::*;
();

    localparam int NODES     = 32;
    localparam int LINKS     = 8;
    localparam int OUTS      = 16;
    localparam int DRAIN     = 2000;
    localparam int CYCLE_CAP = 20000000;

    typedef struct {
        logic [1:0]         func;
        logic [4:0]         node;
        logic [2:0]         slot;
        logic [4:0]         src;
        logic signed [15:0] wt;
        logic [3:0]         cnt;
        logic signed [15:0] val;
        bit                 typed;
        logic [12:0]        tval;
    } t_item;

    typedef struct {
        logic [3:0]  idx;
        logic [12:0] val;
        logic        last;
    } t_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_func;
    logic [4:0]         i_node_index;
    logic [2:0]         i_link_slot;
    logic [4:0]         i_source_node;
    logic signed [15:0] i_link_weight;
    logic [3:0]         i_links_in_use;
    logic signed [15:0] i_input_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [3:0]         o_output_index;
    logic [12:0]        o_output_value;
    logic               o_last;

    sparse_network_relaxation_eval u_dut (.*);

    // Predictor state
    logic [4:0]         link_src_m [NODES*LINKS];
    logic signed [15:0] link_wt_m  [NODES*LINKS];
    bit                 slot_written [NODES*LINKS];
    logic [3:0]         link_cnt_m [NODES];
    logic signed [15:0] node_val_m [NODES];
    bit                 node_rdy_m [NODES];
    logic [5:0]         cfg_inputs, cfg_nodes, cfg_passes;
    logic [4:0]         cfg_outputs;
    int                 sig_points [17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902,
                                            3976, 4022, 4051, 4069, 4079, 4086, 4090,
                                            4092, 4094, 4095};

    t_res pending_outputs [$];
    t_res run_outputs [$];
    t_item directed [$];

    int  errors = 0;
    int  cycle_cnt = 0;
    int  send_idle, recv_idle;
    int  hold_asks = 0, hold_seen = 0, hold_left = 0;

    // Clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls plus a long hold-off once results are waiting
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen && o_out_valid) begin
            hold_seen = hold_asks;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_cnt);
        errors++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                report("unexpected transfer, index", o_output_index, -1);
            end else begin
                e = pending_outputs.pop_front();
                if (o_output_index !== e.idx) report("output_index", o_output_index, e.idx);
                if (o_output_value !== e.val) report("output_value", o_output_value, e.val);
                if (o_last !== e.last) report("last", o_last, e.last);
            end
        end
    end

    function automatic int sigmoid_q12(int x);
        int a, i, fr, d, v;
        a = (x < 0) ? -x : x;
        if (a >= 32768) begin
            v = sig_points[16];
        end else begin
            i  = a >> 11;
            fr = a & 2047;
            d  = sig_points[i+1] - sig_points[i];
            v  = sig_points[i] + ((d * fr + 1024) >>> 11);
        end
        return (x < 0) ? 4096 - v : v;
    endfunction

    // One run: relaxation passes, then the output values, then clearing
    function automatic void relax_network();
        int     ncnt, icnt, ocnt, lim, pc, i, k, at, src, node;
        bit     again;
        longint s, q;
        int     sums [NODES];
        t_res   r;
        ncnt = (cfg_nodes > NODES) ? NODES : cfg_nodes;
        icnt = (cfg_inputs > NODES) ? NODES : cfg_inputs;
        ocnt = (cfg_outputs > OUTS) ? OUTS : cfg_outputs;
        lim  = (cfg_passes == 0) ? 1 : cfg_passes;
        for (i = 0; i < icnt; i++) node_rdy_m[i] = 1'b1;
        pc = 0;
        do begin
            again = 1'b0;
            for (i = cfg_inputs; i < ncnt; i++) begin
                s = 0;
                node_rdy_m[i] = 1'b1;
                for (k = 0; k < link_cnt_m[i]; k++) begin
                    at  = i * LINKS + k;
                    src = link_src_m[at];
                    if (node_rdy_m[src])
                        s += longint'(node_val_m[src]) * longint'(link_wt_m[at]);
                    else
                        node_rdy_m[i] = 1'b0;
                end
                q = s >>> 12;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                sums[i] = int'(q);
            end
            for (i = cfg_inputs; i < ncnt; i++) begin
                if (!node_rdy_m[i]) again = 1'b1;
                else node_val_m[i] = 16'(sigmoid_q12(sums[i]));
            end
            pc = (pc + 1) & 63;
        end while (again && (pc == 0 || pc < lim));
        run_outputs.delete();
        for (k = 0; k < ocnt; k++) begin
            node   = cfg_inputs + k;
            r.idx  = 4'(k);
            r.val  = (node < NODES) ? node_val_m[node][12:0] : 13'd0;
            r.last = (k + 1 == ocnt);
            run_outputs = {run_outputs, r};
        end
        for (i = 0; i < NODES; i++) begin
            node_val_m[i] = '0;
            node_rdy_m[i] = 1'b0;
        end
    endfunction

    // Predictor update for one accepted item
    function automatic void apply_item(t_item it);
        int   at;
        t_res r;
        at = it.node * LINKS + it.slot;
        case (it.func)
            FUNC_LINK: begin
                link_src_m[at]   = it.src;
                link_wt_m[at]    = it.wt;
                slot_written[at] = 1'b1;
            end
            FUNC_COUNT: link_cnt_m[it.node] = (it.cnt > LINKS) ? 4'(LINKS) : it.cnt;
            FUNC_VALUE: node_val_m[it.node] = it.val;
            default: begin
                relax_network();
                if (it.typed) begin
                    r.idx = '0; r.val = it.tval; r.last = 1'b1;
                    pending_outputs = {pending_outputs, r};
                end else begin
                    foreach (run_outputs[j]) pending_outputs = {pending_outputs, run_outputs[j]};
                end
            end
        endcase
    endfunction

    task automatic send_item(t_item it);
        i_in_valid     <= 1'b1;
        i_func         <= it.func;
        i_node_index   <= it.node;
        i_link_slot    <= it.slot;
        i_source_node  <= it.src;
        i_link_weight  <= it.wt;
        i_links_in_use <= it.cnt;
        i_input_value  <= it.val;
        do @(posedge i_clk); while (!o_in_ready);
        apply_item(it);
        if ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_INPUT_COUNT:  cfg_inputs  = d[5:0];
            CFG_OUTPUT_COUNT: cfg_outputs = d[4:0];
            CFG_NODE_COUNT:   cfg_nodes   = d[5:0];
            default:          cfg_passes  = d[5:0];
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Lower valid and wait until the block has delivered everything
    task automatic drain(int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    function automatic t_item mk(logic [1:0] f, int n, int sl, int sr, int w, int c, int v,
                                 bit ty = 0, int tv = 0);
        t_item it;
        it.func = f; it.node = 5'(n); it.slot = 3'(sl); it.src = 5'(sr);
        it.wt = 16'(w); it.cnt = 4'(c); it.val = 16'(v);
        it.typed = ty; it.tval = 13'(tv);
        return it;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_item it);
        directed = {directed, it};
    endfunction

    // Random item, biased towards the nodes in use and towards ready sources
    function automatic t_item random_item();
        t_item it;
        int    r, nmax, maxc;
        r    = $urandom_range(0, 99);
        nmax = (cfg_nodes > NODES) ? NODES : ((cfg_nodes < 1) ? 1 : cfg_nodes);
        it   = mk(FUNC_RUN, $urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 31),
                  $urandom, $urandom_range(0, 15), $urandom);
        if ($urandom_range(0, 99) < 80) it.node = 5'($urandom_range(0, nmax - 1));
        if (r < 45) begin
            it.func = FUNC_LINK;
            if ($urandom_range(0, 99) < 75) it.src = 5'($urandom_range(0, it.node));
            if ($urandom_range(0, 1)) it.wt = 16'($urandom_range(0, 8191) - 4096);
        end else if (r < 65) begin
            it.func = FUNC_COUNT;
            maxc = 0;
            while (maxc < LINKS && slot_written[it.node * LINKS + maxc]) maxc++;
            it.cnt = (maxc == LINKS) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, maxc));
        end else if (r < 85) begin
            it.func = FUNC_VALUE;
            if ($urandom_range(0, 1)) it.val = 16'($urandom_range(0, 8191) - 4096);
        end
        return it;
    endfunction

    task automatic run_phase(int ic, int oc, int nc, int pl, int sid, int rid, int n,
                             bit hold, bit pause);
        cfg_write(CFG_INPUT_COUNT,  {2'($urandom), 6'(ic)});
        cfg_write(CFG_OUTPUT_COUNT, {3'($urandom), 5'(oc)});
        cfg_write(CFG_NODE_COUNT,   {2'($urandom), 6'(nc)});
        cfg_write(CFG_PASS_LIMIT,   {2'($urandom), 6'(pl)});
        send_idle = sid;
        recv_idle = rid;
        if (hold) hold_asks++;
        for (int j = 0; j < n; j++) begin
            if (pause && j == n / 2) drain(0);
            send_item(random_item());
        end
        drain(DRAIN);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_func = '0; i_node_index = '0; i_link_slot = '0;
        i_source_node = '0; i_link_weight = '0; i_links_in_use = '0; i_input_value = '0;
        i_out_ready = 1'b0;
        send_idle = 16; recv_idle = 55;
        cfg_inputs = INPUT_COUNT_RST; cfg_outputs = OUTPUT_COUNT_RST;
        cfg_nodes = NODE_COUNT_RST; cfg_passes = PASS_LIMIT_RST;
        for (int j = 0; j < NODES * LINKS; j++) begin
            link_src_m[j] = '0; link_wt_m[j] = '0; slot_written[j] = 1'b0;
        end
        for (int j = 0; j < NODES; j++) begin
            link_cnt_m[j] = '0; node_val_m[j] = '0; node_rdy_m[j] = 1'b0;
        end

        // Directed table, under the reset register values
        add_row(mk(FUNC_RUN,   0, 0, 0, 0, 0, 0, 1, 2048));    // empty node: sig(0)
        add_row(mk(FUNC_VALUE, 0, 0, 0, 0, 0, 'h7FFF));
        add_row(mk(FUNC_LINK,  1, 0, 0, 'h7FFF, 0, 0));
        add_row(mk(FUNC_COUNT, 1, 0, 0, 0, 1, 0));
        add_row(mk(FUNC_RUN,   0, 0, 0, 0, 0, 0, 1, 4095));    // saturates high
        add_row(mk(FUNC_VALUE, 0, 0, 0, 0, 0, 'h8000));
        add_row(mk(FUNC_RUN,   0, 0, 0, 0, 0, 0, 1, 1));       // saturates low
        add_row(mk(FUNC_LINK,  1, 0, 0, 'h8000, 0, 0));
        add_row(mk(FUNC_VALUE, 0, 0, 0, 0, 0, 'h8000));
        add_row(mk(FUNC_RUN,   0, 0, 0, 0, 0, 0));
        add_row(mk(FUNC_LINK,  1, 1, 1, 'h1000, 0, 0));        // self link
        for (int s = 2; s < 7; s++)
            add_row(mk(FUNC_LINK, 1, s, 0, $urandom_range(0, 8191) - 4096, 0, 0));
        add_row(mk(FUNC_LINK,  1, 7, 31, 'h1234, 0, 0));       // never-ready source
        add_row(mk(FUNC_COUNT, 1, 0, 0, 0, 15, 0));            // count saturates
        add_row(mk(FUNC_VALUE, 0, 0, 0, 0, 0, 'h0800));
        add_row(mk(FUNC_RUN,   0, 0, 0, 0, 0, 0));             // runs to pass limit
        add_row(mk(FUNC_COUNT, 1, 0, 0, 0, 7, 0));
        add_row(mk(FUNC_VALUE, 1, 0, 0, 0, 0, 'h0C00));        // non-input value
        add_row(mk(FUNC_VALUE, 0, 0, 0, 0, 0, 'hF000));
        add_row(mk(FUNC_RUN,   0, 0, 0, 0, 0, 0));
        add_row(mk(FUNC_LINK,  0, 0, 5, 1, 0, 0));             // link on input node

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[j]) send_item(directed[j]);
        drain(DRAIN);

        // Random phases: register settings and idling patterns
        run_phase(2,  3,  8,  4,  16, 55, 34, 0, 1);
        run_phase(32, 16, 32, 1,  16, 55, 34, 0, 1);   // too many inputs
        run_phase(1,  16, 32, 32, 55, 16, 34, 1, 0);
        run_phase(3,  4,  10, 0,  55, 16, 34, 0, 0);   // zero pass limit
        run_phase(4,  16, 63, 63, 0,  0,  36, 0, 0);   // node count saturates
        run_phase(1,  0,  6,  5,  0,  0,  34, 0, 0);   // no outputs

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
